// ----- src/pfre_pkg.sv -----
// Shared types, constants and helpers for the page framebuffer draw engine.
// No dependencies; imported by every module of the block.
package pfre_pkg;

  // Framebuffer geometry (powers of two)
  localparam int COLUMNS   = 128;
  localparam int PAGES     = 8;
  localparam int COL_BITS  = $clog2(COLUMNS);
  localparam int PAGE_BITS = $clog2(PAGES);
  localparam int ADDR_W    = COL_BITS + PAGE_BITS;
  localparam int DEPTH     = COLUMNS * PAGES;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int POS_W  = 8;
  localparam int DATA_W = 8;
  // Page index of an 8-bit row (row / 8)
  localparam int PG_W   = POS_W - 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PIXEL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HLINE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_VLINE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FILL    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_OUTLINE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd6;

  // Command classes seen by the controller
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_DRAW  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [1:0] SEG_FIRST = 2'd0;
  localparam logic [1:0] SEG_FINAL = 2'd3;

  localparam logic [DATA_W-1:0] MASK_ALL = 8'hff;

  // Controller to datapath commands
  typedef struct packed {
    logic       take_in;
    logic       clr_step;
    logic       seg_load;
    logic [1:0] seg_idx;
    logic       rd_issue;
    logic       wr_do;
    logic       rdb_issue;
    logic       out_load;
  } pfre_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       seg_last;
    logic       walk_empty;
    logic       walk_last;
    logic       clr_last;
    logic       out_busy;
  } pfre_sts_t;

  // Single pixel bit within a page byte
  function automatic logic [DATA_W-1:0] bit_mask(input logic [2:0] row_bit);
    bit_mask = 8'h01 << row_bit;
  endfunction

  // Bits from row_bit down to the bottom of the byte
  function automatic logic [DATA_W-1:0] head_mask(input logic [2:0] row_bit);
    head_mask = MASK_ALL << row_bit;
  endfunction

  // Bits from the top of the byte down to row_bit
  function automatic logic [DATA_W-1:0] tail_mask(input logic [2:0] row_bit);
    tail_mask = MASK_ALL >> (3'd7 - row_bit);
  endfunction

  // Inclusive end of a span, held at 255
  function automatic logic [POS_W-1:0] span_end(input logic [POS_W-1:0] start,
                                                input logic [POS_W-1:0] len);
    logic [POS_W:0] sum;
    sum = {1'b0, start} + {1'b0, len} - {{POS_W{1'b0}}, 1'b1};
    span_end = sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];
  endfunction

endpackage

// ----- src/pfre_ctrl.sv -----
// Controller state machine of the page framebuffer draw engine.
// Depends on pfre_pkg; drives pfre_datapath through command/status structs.
module pfre_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pfre_pkg::pfre_sts_t sts,
  output pfre_pkg::pfre_cmd_t cmd
);
  import pfre_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_SEG  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_WR   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic       boot_r, boot_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      seg_r   <= SEG_FIRST;
      boot_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
      boot_r  <= boot_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    boot_nxt  = boot_r;
    cmd       = '0;
    cmd.seg_idx = seg_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          boot_nxt  = 1'b0;
          state_nxt = boot_r ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.kind)
          KIND_CLEAR: state_nxt = S_CLR;
          KIND_READ: begin
            cmd.rdb_issue = 1'b1;
            state_nxt     = S_DONE;
          end
          KIND_DRAW: begin
            seg_nxt   = SEG_FIRST;
            state_nxt = S_SEG;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SEG: begin
        cmd.seg_load = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        if (!sts.walk_empty) begin
          state_nxt = S_RD;
        end else if (sts.seg_last) begin
          state_nxt = S_DONE;
        end else begin
          seg_nxt   = seg_r + 2'd1;
          state_nxt = S_SEG;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_WR;
      end
      S_WR: begin
        cmd.wr_do = 1'b1;
        if (!sts.walk_last) begin
          state_nxt = S_RD;
        end else if (sts.seg_last) begin
          state_nxt = S_DONE;
        end else begin
          seg_nxt   = seg_r + 2'd1;
          state_nxt = S_SEG;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- src/pfre_datapath.sv -----
// Datapath of the page framebuffer draw engine: command word registers,
// span walker, pixel memory with read-modify-write, and output register.
// Depends on pfre_pkg; controlled by pfre_ctrl.
module pfre_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [pfre_pkg::CMD_W-1:0]        in_command,
  input  logic [pfre_pkg::POS_W-1:0]        in_x_pos,
  input  logic [pfre_pkg::POS_W-1:0]        in_y_pos,
  input  logic [pfre_pkg::POS_W-1:0]        in_x_span,
  input  logic [pfre_pkg::POS_W-1:0]        in_y_span,
  input  logic                              in_color,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pfre_pkg::DATA_W-1:0]       out_read_data,
  input  pfre_pkg::pfre_cmd_t               cmd,
  output pfre_pkg::pfre_sts_t               sts
);
  import pfre_pkg::*;

  // Captured input word
  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] x_r, y_r, xs_r, ys_r;
  logic             color_r;

  // Walker registers
  logic [POS_W-1:0]  xa_r, xb_r, col_r;
  logic [PG_W-1:0]   pa_r, pb_r, pg_r;
  logic [DATA_W-1:0] fm_r, lm_r;
  logic              empty_r;

  // Memory, clear counter, output
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  // Segment setup values
  logic [POS_W-1:0]  x1, y1;
  logic [POS_W-1:0]  sxa, sxb;
  logic [PG_W-1:0]   spa, spb;
  logic [DATA_W-1:0] sfm, slm;
  logic [1:0]        kind;
  logic              draw_color;
  logic [DATA_W-1:0] cur_mask, wr_data;
  logic [ADDR_W-1:0] walk_addr, rdb_addr;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      cmd_r   <= in_command;
      x_r     <= in_x_pos;
      y_r     <= in_y_pos;
      xs_r    <= in_x_span;
      ys_r    <= in_y_span;
      color_r <= in_color;
    end
  end

  // Command class
  always_comb begin
    case (cmd_r)
      CMD_CLEAR: kind = KIND_CLEAR;
      CMD_READ:  kind = KIND_READ;
      CMD_PIXEL, CMD_HLINE, CMD_VLINE: kind = KIND_DRAW;
      CMD_FILL, CMD_OUTLINE:
        kind = (xs_r == '0 || ys_r == '0) ? KIND_NONE : KIND_DRAW;
      default:   kind = KIND_NONE;
    endcase
  end

  assign x1 = span_end(x_r, xs_r);
  assign y1 = span_end(y_r, ys_r);
  assign draw_color = (cmd_r == CMD_VLINE) ? 1'b1 : color_r;

  // Segment bounds: columns xa..xb, pages pa..pb, head and tail masks
  always_comb begin
    sxa = x_r;
    sxb = x_r;
    spa = y_r[POS_W-1:3];
    spb = y_r[POS_W-1:3];
    sfm = bit_mask(y_r[2:0]);
    slm = MASK_ALL;
    case (cmd_r)
      CMD_HLINE: sxb = xs_r;
      CMD_VLINE: begin
        spb = ys_r[POS_W-1:3];
        sfm = head_mask(y_r[2:0]);
        slm = tail_mask(ys_r[2:0]);
      end
      CMD_FILL: begin
        sxb = x1;
        spb = y1[POS_W-1:3];
        sfm = head_mask(y_r[2:0]);
        slm = tail_mask(y1[2:0]);
      end
      CMD_OUTLINE: begin
        case (cmd.seg_idx)
          2'd0: sxb = x1;
          2'd1: begin
            sxb = x1;
            spa = y1[POS_W-1:3];
            spb = y1[POS_W-1:3];
            sfm = bit_mask(y1[2:0]);
          end
          2'd2: begin
            spb = y1[POS_W-1:3];
            sfm = head_mask(y_r[2:0]);
            slm = tail_mask(y1[2:0]);
          end
          default: begin
            sxa = x1;
            sxb = x1;
            spb = y1[POS_W-1:3];
            sfm = head_mask(y_r[2:0]);
            slm = tail_mask(y1[2:0]);
          end
        endcase
      end
      default: ;
    endcase
  end

  // Span walker: columns inner, pages outer
  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      xa_r    <= sxa;
      xb_r    <= sxb;
      pa_r    <= spa;
      pb_r    <= spb;
      fm_r    <= sfm;
      lm_r    <= slm;
      col_r   <= sxa;
      pg_r    <= spa;
      empty_r <= (sxa > sxb) || (spa > spb);
    end else if (cmd.wr_do) begin
      if (col_r == xb_r) begin
        col_r <= xa_r;
        pg_r  <= pg_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  assign cur_mask  = ((pg_r == pa_r) ? fm_r : MASK_ALL) & ((pg_r == pb_r) ? lm_r : MASK_ALL);
  assign wr_data   = draw_color ? (rd_data_r | cur_mask) : (rd_data_r & ~cur_mask);
  assign walk_addr = {pg_r[PAGE_BITS-1:0], col_r[COL_BITS-1:0]};
  assign rdb_addr  = {y_r[3 +: PAGE_BITS], x_r[COL_BITS-1:0]};

  // Pixel memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.wr_do) begin
      mem[walk_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[walk_addr];
    end else if (cmd.rdb_issue) begin
      rd_data_r <= mem[rdb_addr];
    end
  end

  // Clear sweep address; wraps back to zero at the end of each pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= (cmd_r == CMD_READ) ? rd_data_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // Status back to the controller
  assign sts.kind       = kind;
  assign sts.seg_last   = (cmd_r != CMD_OUTLINE) || (cmd.seg_idx == SEG_FINAL);
  assign sts.walk_empty = empty_r;
  assign sts.walk_last  = (col_r == xb_r) && (pg_r == pb_r);
  assign sts.clr_last   = &clr_addr_r;
  assign sts.out_busy   = out_valid_r && out_stall;

endmodule

// ----- src/page_framebuffer_raster_engine_unit.sv -----
// Channel   Direction  Ports                                       Word
// input     in         in_valid/in_stall, in_command..in_color     one draw command
// result    out        out_valid/out_stall, out_read_data          one byte per command
//
// Each pixel byte touched takes a memory read, then a masked write, on the
// single-port pixel memory. A draw command walks its segments one after another
// (outline: four segments, other draws one); read, unused code and zero-size
// rectangles walk no segment.
// Clear walks all 1024 bytes, one write a cycle.
// After reset the same clearing pass runs with in_stall high.
// One command is in work at a time; a result waiting under out_stall holds the
// next result back but not the acceptance of the next command.
// Top level; depends on pfre_pkg, pfre_ctrl and pfre_datapath.
module page_framebuffer_raster_engine_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pfre_pkg::CMD_W-1:0]     in_command,
  input  logic [pfre_pkg::POS_W-1:0]     in_x_pos,
  input  logic [pfre_pkg::POS_W-1:0]     in_y_pos,
  input  logic [pfre_pkg::POS_W-1:0]     in_x_span,
  input  logic [pfre_pkg::POS_W-1:0]     in_y_span,
  input  logic                           in_color,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pfre_pkg::DATA_W-1:0]    out_read_data
);
  import pfre_pkg::*;

  pfre_cmd_t dp_cmd;
  pfre_sts_t dp_sts;

  // Controller
  pfre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // Datapath
  pfre_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_command),
    .in_x_pos      (in_x_pos),
    .in_y_pos      (in_y_pos),
    .in_x_span     (in_x_span),
    .in_y_span     (in_y_span),
    .in_color      (in_color),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .cmd           (dp_cmd),
    .sts           (dp_sts)
  );

  // Reset starts the clearing pass, so no word is taken right after it
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during reset clearing pass");

  // One command in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while a command is in work");

  // Memory is only written while a command or clear pass is in work
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.wr_do || dp_cmd.clr_step) |-> in_stall)
    else $error("pixel memory written while idle");

  // A result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwrote a stalled output word");

endmodule

// ----- tb/page_framebuffer_raster_engine_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench for page_framebuffer_raster_engine_unit: directed and random draw commands
// checked against an in-bench image of the 128x8-page framebuffer, one result word each.
// Depends on pfre_pkg and the engine RTL only.
module page_framebuffer_raster_engine_unit_tb;
  import pfre_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam int HOLD_CYCLES  = 4000;
  localparam int DRAIN_CYCLES = 20000;

  // receiver stall modes
  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command;
  logic [POS_W-1:0]  in_x_pos;
  logic [POS_W-1:0]  in_y_pos;
  logic [POS_W-1:0]  in_x_span;
  logic [POS_W-1:0]  in_y_span;
  logic              in_color;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] out_read_data;

  page_framebuffer_raster_engine_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_x_pos     (in_x_pos),
    .in_y_pos     (in_y_pos),
    .in_x_span    (in_x_span),
    .in_y_span    (in_y_span),
    .in_color     (in_color),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_read_data(out_read_data)
  );

  // Image of the framebuffer as the engine should hold it
  logic [DATA_W-1:0] frame_image [0:DEPTH-1];
  // Read bytes still owed by the engine, oldest first
  logic [DATA_W-1:0] read_bytes_due [$];

  int mismatch_count;
  int result_count;
  int burst_left;
  bit gaps_on;
  int hold_requests;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("page_framebuffer_raster_engine_unit_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Framebuffer image
  // ---------------------------------------------------------------------------

  // Masked read-modify-write of one byte; column and page wrap
  function automatic void put_bits(int col, int page, logic [DATA_W-1:0] mask,
                                   logic color);
    int idx;
    idx = (page % PAGES) * COLUMNS + (col % COLUMNS);
    if (color) frame_image[idx] = frame_image[idx] | mask;
    else       frame_image[idx] = frame_image[idx] & ~mask;
  endfunction

  // One pixel row from column x0 to x1, never past column 255
  function automatic void draw_row(int x0, int x1, int y, logic color);
    int xi;
    for (xi = x0; xi <= x1 && xi <= 255; xi++)
      put_bits(xi, y / 8, 8'h01 << (y % 8), color);
  endfunction

  // One column from row y0 to y1, masked in the first and last page
  function automatic void draw_col(int x, int y0, int y1, logic color);
    int pg;
    int pg_end;
    logic [DATA_W-1:0] mask;
    pg     = y0 / 8;
    pg_end = y1 / 8;
    mask   = 8'hff << (y0 % 8);
    while (pg <= pg_end) begin
      if (pg == pg_end) mask = mask & (8'hff >> (7 - (y1 % 8)));
      put_bits(x, pg, mask, color);
      mask = 8'hff;
      pg++;
    end
  endfunction

  // Inclusive end of a rectangle side, held at 255
  function automatic int clip_end(int start, int len);
    int e;
    e = start + len - 1;
    return (e > 255) ? 255 : e;
  endfunction

  function automatic logic [POS_W-1:0] lim255(int v);
    return (v > 255) ? 8'd255 : v[POS_W-1:0];
  endfunction

  // Applies one command to the image and returns the byte the engine answers with
  function automatic logic [DATA_W-1:0] apply_command(logic [CMD_W-1:0] cmd,
      logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] xs,
      logic [POS_W-1:0] ys, logic color);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] mask;
    int x1;
    int y1;
    int pg;
    int pg_end;
    int xi;
    int i;
    rd = '0;
    case (cmd)
      CMD_CLEAR: begin
        for (i = 0; i < DEPTH; i++) frame_image[i] = '0;
      end
      CMD_PIXEL: put_bits(x, y / 8, 8'h01 << y[2:0], color);
      CMD_HLINE: draw_row(x, xs, y, color);
      CMD_VLINE: draw_col(x, y, ys, 1'b1);   // vline ignores color
      CMD_FILL: begin
        if (xs != 0 && ys != 0) begin
          x1     = clip_end(x, xs);
          y1     = clip_end(y, ys);
          pg     = y / 8;
          pg_end = y1 / 8;
          mask   = 8'hff << y[2:0];
          while (pg <= pg_end) begin
            if (pg == pg_end) mask = mask & (8'hff >> (7 - (y1 % 8)));
            for (xi = x; xi <= x1; xi++) put_bits(xi, pg, mask, color);
            mask = 8'hff;
            pg++;
          end
        end
      end
      CMD_OUTLINE: begin
        if (xs != 0 && ys != 0) begin
          x1 = clip_end(x, xs);
          y1 = clip_end(y, ys);
          draw_row(x, x1, y, color);
          draw_row(x, x1, y1, color);
          draw_col(x, y, y1, color);
          draw_col(x1, y, y1, color);
        end
      end
      CMD_READ: rd = frame_image[((y / 8) % PAGES) * COLUMNS + (x % COLUMNS)];
      default: ;
    endcase
    return rd;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one command word per call, bursts with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] x,
                          input logic [POS_W-1:0] y, input logic [POS_W-1:0] xs,
                          input logic [POS_W-1:0] ys, input logic color);
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command <= cmd;
    in_x_pos   <= x;
    in_y_pos   <= y;
    in_x_span  <= xs;
    in_y_span  <= ys;
    in_color   <= color;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    read_bytes_due.push_back(apply_command(cmd, x, y, xs, ys, color));
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall pattern, with a counted long hold on request
  // ---------------------------------------------------------------------------
  initial begin : receiver_pattern
    int mode;
    int mode_left;
    int hold_left;
    int holds_done;
    logic stall_next;
    mode       = STALL_NONE;
    mode_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(STALL_NONE, STALL_PERIODIC);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  stall_next = 1'b0;
          STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: stall_next = ($urandom_range(0, 9) < 7);
          default:     stall_next = ((mode_left % 7) < 3);
        endcase
      end
      out_stall <= stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest owed byte
  // ---------------------------------------------------------------------------
  task automatic note_error(input string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (read_bytes_due.size() == 0) begin
        note_error($sformatf("result %0d: unexpected word, read_data %02h",
                             result_count, out_read_data));
      end else begin
        if (out_read_data !== read_bytes_due[0])
          note_error($sformatf("result %0d: read_data expected %02h actual %02h",
                               result_count, read_bytes_due[0], out_read_data));
        void'(read_bytes_due.pop_front());
      end
      result_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Cleared store after reset, single pixels at the far corner, wrap of columns and pages
  task automatic test_reset_and_pixel();
    send_cmd(CMD_READ,  8'd5,   8'd17,  8'd0, 8'd0, 1'b0);
    send_cmd(CMD_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1);
    send_cmd(CMD_READ,  8'd127, 8'd63,  8'd0, 8'd0, 1'b0);
    send_cmd(CMD_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0);
    send_cmd(CMD_READ,  8'd255, 8'd255, 8'd0, 8'd0, 1'b1);
  endtask

  // Lines: end at 255, reversed hline, vline ignoring color, empty same-page vline
  task automatic test_lines();
    send_cmd(CMD_HLINE, 8'd250, 8'd9,  8'd255, 8'd0,  1'b1);
    send_cmd(CMD_READ,  8'd124, 8'd9,  8'd0,   8'd0,  1'b0);
    send_cmd(CMD_HLINE, 8'd10,  8'd0,  8'd5,   8'd0,  1'b1);
    send_cmd(CMD_VLINE, 8'd3,   8'd5,  8'd0,   8'd20, 1'b0);
    send_cmd(CMD_READ,  8'd3,   8'd16, 8'd0,   8'd0,  1'b0);
    send_cmd(CMD_VLINE, 8'd6,   8'd6,  8'd0,   8'd2,  1'b1);
    send_cmd(CMD_READ,  8'd6,   8'd0,  8'd0,   8'd0,  1'b0);
  endtask

  // Rectangles: full-range fill, zero width and height, clipped spans, outline
  task automatic test_rects();
    send_cmd(CMD_FILL,    8'd0,   8'd0,   8'd255, 8'd255, 1'b1);
    send_cmd(CMD_FILL,    8'd7,   8'd9,   8'd0,   8'd40,  1'b0);
    send_cmd(CMD_FILL,    8'd7,   8'd9,   8'd40,  8'd0,   1'b0);
    send_cmd(CMD_OUTLINE, 8'd0,   8'd0,   8'd255, 8'd255, 1'b0);
    send_cmd(CMD_READ,    8'd64,  8'd100, 8'd0,   8'd0,   1'b0);
    send_cmd(CMD_READ,    8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
    send_cmd(CMD_FILL,    8'd200, 8'd250, 8'd255, 8'd255, 1'b0);
    send_cmd(CMD_READ,    8'd210, 8'd255, 8'd0,   8'd0,   1'b0);
  endtask

  // Unused command code and clear
  task automatic test_clear_and_unused();
    send_cmd(CMD_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_cmd(CMD_CLEAR,  8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_cmd(CMD_READ,   8'd127, 8'd255, 8'd0,   8'd0,   1'b0);
  endtask

  // Random command mix; rectangles mostly small, reads often aimed at the last drawing
  task automatic test_random_mix(input int count);
    int n;
    int pick;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] xs;
    logic [POS_W-1:0] ys;
    logic [POS_W-1:0] last_x;
    logic [POS_W-1:0] last_y;
    logic color;
    last_x = '0;
    last_y = '0;
    for (n = 0; n < count; n++) begin
      pick  = $urandom_range(0, 99);
      x     = POS_W'($urandom_range(0, 255));
      y     = POS_W'($urandom_range(0, 255));
      xs    = POS_W'($urandom_range(0, 255));
      ys    = POS_W'($urandom_range(0, 255));
      color = 1'($urandom_range(0, 1));
      if (pick < 3) begin
        send_cmd(CMD_CLEAR, x, y, xs, ys, color);
      end else if (pick < 33) begin
        if ($urandom_range(0, 1) == 0) begin
          x = POS_W'(last_x + $urandom_range(0, 3));
          y = POS_W'(last_y + 8 * $urandom_range(0, 1));
        end
        send_cmd(CMD_READ, x, y, xs, ys, color);
      end else if (pick < 45) begin
        send_cmd(CMD_PIXEL, x, y, xs, ys, color);
      end else if (pick < 57) begin
        if ($urandom_range(0, 3) != 0) xs = lim255(x + $urandom_range(0, 48));
        send_cmd(CMD_HLINE, x, y, xs, ys, color);
      end else if (pick < 67) begin
        if ($urandom_range(0, 3) != 0) ys = lim255(y + $urandom_range(0, 40));
        send_cmd(CMD_VLINE, x, y, xs, ys, color);
      end else if (pick < 83) begin
        if ($urandom_range(0, 24) != 0) begin
          xs = POS_W'($urandom_range(0, 18));
          ys = POS_W'($urandom_range(0, 20));
        end
        send_cmd(CMD_FILL, x, y, xs, ys, color);
      end else if (pick < 95) begin
        if ($urandom_range(0, 1) == 0) begin
          xs = POS_W'($urandom_range(0, 24));
          ys = POS_W'($urandom_range(0, 24));
        end
        send_cmd(CMD_OUTLINE, x, y, xs, ys, color);
      end else begin
        send_cmd(CMD_UNUSED, x, y, xs, ys, color);
      end
      if (pick >= 33) begin
        last_x = x;
        last_y = y;
      end
    end
  endtask

  // Receiver holds off for a long stretch while commands keep coming without gaps
  task automatic test_full_stall();
    int n;
    hold_requests++;
    gaps_on = 1'b0;
    for (n = 0; n < 12; n++) begin
      if (n % 2 == 0)
        send_cmd(CMD_PIXEL, POS_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 255)),
                 8'd0, 8'd0, 1'($urandom_range(0, 1)));
      else
        send_cmd(CMD_READ, POS_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 255)),
                 8'd0, 8'd0, 1'b0);
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    int i;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_CLEAR;
    in_x_pos       = '0;
    in_y_pos       = '0;
    in_x_span      = '0;
    in_y_span      = '0;
    in_color       = 1'b0;
    gaps_on        = 1'b1;
    burst_left     = 0;
    hold_requests  = 0;
    mismatch_count = 0;
    result_count   = 0;
    for (i = 0; i < DEPTH; i++) frame_image[i] = '0;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_and_pixel();
    test_lines();
    test_rects();
    test_clear_and_unused();
    test_random_mix(275);
    test_full_stall();
    test_random_mix(275);
    in_valid <= 1'b0;

    // drain, then watch for stray words
    while (read_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && read_bytes_due.size() == 0) begin
      $display("page_framebuffer_raster_engine_unit_tb passed");
    end else begin
      $display("page_framebuffer_raster_engine_unit_tb failed");
    end
    $finish;
  end

endmodule

// ----- page_framebuffer_raster_engine_unit.f -----
src/pfre_pkg.sv
src/pfre_ctrl.sv
src/pfre_datapath.sv
src/page_framebuffer_raster_engine_unit.sv
tb/page_framebuffer_raster_engine_unit_tb.sv
